### sv/pms_pkg.sv
`timescale 1ns / 1ps

package pms_pkg;

	// Field widths
	localparam int GAIN_W   = 16;
	localparam int ILIM_W   = 15;
	localparam int DLIM_W   = 7;
	localparam int SCALE_W  = 10;
	localparam int ID_W     = 11;
	localparam int WORD_W   = 16;
	localparam int PULSE_W  = 16;
	localparam int DRIVE_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Internal arithmetic widths
	localparam int MAG_W    = PULSE_W + SCALE_W;	// raw pulse * scale
	localparam int ERR_W    = WORD_W + 1;		// target - speed
	localparam int SUM_W    = WORD_W;		// clamped integrator
	localparam int WIDE_W   = ERR_W + 1;		// integrator add, derivative
	localparam int PP_W     = GAIN_W + 1 + ERR_W;	// prop product
	localparam int PI_W     = GAIN_W + 1 + SUM_W;	// integ product
	localparam int PD_W     = GAIN_W + 1 + WIDE_W;	// deriv product
	localparam int ACC_W    = 36;

	// Request kinds
	localparam logic REQ_COMMAND = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_PULSE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_ID    = 3'd6;

	// Register reset values
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 16'd983;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN    = 16'd1966;
	localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 16'd2621;
	localparam logic [ILIM_W-1:0]  RST_INTEG_LIMIT   = 15'd8000;
	localparam logic [DLIM_W-1:0]  RST_DRIVE_LIMIT   = 7'd100;
	localparam logic [SCALE_W-1:0] RST_RPM_PER_PULSE = 10'd200;
	localparam logic [ID_W-1:0]    RST_COMMAND_ID    = 11'd512;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [ILIM_W-1:0]  integ_limit;
		logic [DLIM_W-1:0]  drive_limit;
		logic [SCALE_W-1:0] rpm_per_pulse;
		logic [ID_W-1:0]    command_id;
	} cfg_t;

	// Per-tick terms handed from the error stage to the drive stage
	typedef struct packed {
		logic signed [WORD_W-1:0] rpm;
		logic signed [ERR_W-1:0]  err;
		logic signed [SUM_W-1:0]  sum;
		logic signed [WIDE_W-1:0] deriv;
		logic                     tgt_zero;
	} step_t;

endpackage

### sv/pid_motor_speed_loop.sv
`timescale 1ns / 1ps

// Channel   Handshake            Word
// -------   ------------------   ------------------------------------------------
// in        in_valid / in_stall  req_type, frame_id, frame_standard, target_word,
//                                pulse_count
// out       out_valid/out_stall  measured_rpm, drive_level (one word per tick)
// cfg       cfg_we               cfg_idx, cfg_data (write only)
//
// One word is accepted per cycle while in_stall is low. A tick's result passes
// the input, error-stage and product registers before the output register;
// command words give no result. The loop state (target, integrator, last error)
// updates in the error stage, so back-to-back ticks see each other's state.
// arst_n clears all valids, the loop state and loads the register defaults.
// A stalled output parks one word in a skid register; in_stall is that
// register's full flag, and the whole pipeline holds while it is set.

module pid_motor_speed_loop #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pms_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [pms_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [pms_pkg::ID_W-1:0]             frame_id,
	input  logic                                 frame_standard,
	input  logic signed [pms_pkg::WORD_W-1:0]    target_word,
	input  logic [pms_pkg::PULSE_W-1:0]          pulse_count,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pms_pkg::WORD_W-1:0]    measured_rpm,
	output logic signed [pms_pkg::DRIVE_W-1:0]   drive_level
);
	import pms_pkg::*;

	cfg_t                      cfg;
	logic                      adv;
	logic                      skid_full;
	logic                      valid_s2;
	step_t                     step_s2;
	logic                      res_valid;
	logic signed [WORD_W-1:0]  res_rpm;
	logic signed [DRIVE_W-1:0] res_drive;

	// Advance every stage unless the skid register is occupied
	assign adv      = !skid_full;
	assign in_stall = skid_full;

	pms_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Input register, speed scaling, error and clamped integrator
	pms_err_stage u_err (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.req_type       (req_type),
		.frame_id       (frame_id),
		.frame_standard (frame_standard),
		.target_word    (target_word),
		.pulse_count    (pulse_count),
		.valid_s2       (valid_s2),
		.step_s2        (step_s2)
	);

	// Gain products, weighted sum, truncation and drive clamp
	pms_drive_stage #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_drive (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.step_s2   (step_s2),
		.res_valid (res_valid),
		.res_rpm   (res_rpm),
		.res_drive (res_drive)
	);

	// Output register plus one-word skid
	pms_out_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv && res_valid),
		.res_rpm      (res_rpm),
		.res_drive    (res_drive),
		.skid_full    (skid_full),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.measured_rpm (measured_rpm),
		.drive_level  (drive_level)
	);

endmodule

### sv/pms_cfg_regs.sv
`timescale 1ns / 1ps

module pms_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pms_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pms_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pms_pkg::cfg_t                     cfg
);
	import pms_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= RST_PROP_GAIN;
			cfg_q.integ_gain    <= RST_INTEG_GAIN;
			cfg_q.deriv_gain    <= RST_DERIV_GAIN;
			cfg_q.integ_limit   <= RST_INTEG_LIMIT;
			cfg_q.drive_limit   <= RST_DRIVE_LIMIT;
			cfg_q.rpm_per_pulse <= RST_RPM_PER_PULSE;
			cfg_q.command_id    <= RST_COMMAND_ID;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:    cfg_q.integ_gain    <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:    cfg_q.deriv_gain    <= cfg_data[GAIN_W-1:0];
				REG_INTEG_LIMIT:   cfg_q.integ_limit   <= cfg_data[ILIM_W-1:0];
				REG_DRIVE_LIMIT:   cfg_q.drive_limit   <= cfg_data[DLIM_W-1:0];
				REG_RPM_PER_PULSE: cfg_q.rpm_per_pulse <= cfg_data[SCALE_W-1:0];
				REG_COMMAND_ID:    cfg_q.command_id    <= cfg_data[ID_W-1:0];
				default:           cfg_q <= cfg_q;	// unknown index: drop
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/pms_err_stage.sv
`timescale 1ns / 1ps

module pms_err_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  pms_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	input  logic                                req_type,
	input  logic [pms_pkg::ID_W-1:0]            frame_id,
	input  logic                                frame_standard,
	input  logic signed [pms_pkg::WORD_W-1:0]   target_word,
	input  logic [pms_pkg::PULSE_W-1:0]         pulse_count,
	output logic                                valid_s2,
	output pms_pkg::step_t                      step_s2
);
	import pms_pkg::*;

	logic                      valid_s1;
	logic                      type_s1;
	logic [ID_W-1:0]           id_s1;
	logic                      std_s1;
	logic signed [WORD_W-1:0]  tgt_s1;
	logic [PULSE_W-1:0]        pulse_s1;

	logic signed [WORD_W-1:0]  target_q;
	logic signed [SUM_W-1:0]   error_sum_q;
	logic signed [ERR_W-1:0]   last_error_q;

	logic [MAG_W-1:0]          mag;
	logic [WORD_W-2:0]         mag_sat;
	logic signed [WORD_W-1:0]  rpm;
	logic signed [ERR_W-1:0]   err;
	logic signed [WIDE_W-1:0]  sum_raw;
	logic signed [WIDE_W-1:0]  lim;
	logic signed [WIDE_W-1:0]  sum_clamped;
	logic signed [WIDE_W-1:0]  deriv;
	logic                      cmd_hit;
	logic                      tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			type_s1  <= req_type;
			id_s1    <= frame_id;
			std_s1   <= frame_standard;
			tgt_s1   <= target_word;
			pulse_s1 <= pulse_count;
		end
	end

	// Speed: scale the pulse count, saturate, take the target's sign
	always_comb begin
		mag     = MAG_W'(pulse_s1) * MAG_W'(cfg.rpm_per_pulse);
		mag_sat = (|mag[MAG_W-1:WORD_W-1]) ? {(WORD_W-1){1'b1}} : mag[WORD_W-2:0];
		rpm     = target_q[WORD_W-1] ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
		err     = ERR_W'(target_q) - ERR_W'(rpm);
		sum_raw = WIDE_W'(error_sum_q) + WIDE_W'(err);
		lim     = $signed({{(WIDE_W-ILIM_W){1'b0}}, cfg.integ_limit});
		if (sum_raw > lim)
			sum_clamped = lim;
		else if (sum_raw < -lim)
			sum_clamped = -lim;
		else
			sum_clamped = sum_raw;
		deriv   = WIDE_W'(err) - WIDE_W'(last_error_q);
		cmd_hit = (type_s1 == REQ_COMMAND) && std_s1 && (id_s1 == cfg.command_id);
		tick    = (type_s1 == REQ_TICK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (adv && valid_s1) begin
			if (cmd_hit) begin
				target_q     <= tgt_s1;
				error_sum_q  <= '0;
				last_error_q <= '0;
			end else if (tick) begin
				error_sum_q  <= sum_clamped[SUM_W-1:0];
				last_error_q <= err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && tick;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_s2.rpm      <= rpm;
			step_s2.err      <= err;
			step_s2.sum      <= sum_clamped[SUM_W-1:0];
			step_s2.deriv    <= deriv;
			step_s2.tgt_zero <= (target_q == '0);
		end
	end

	a_cmd_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && cmd_hit |=> (error_sum_q == '0) && (last_error_q == '0))
		else $error("integrator not cleared after matching command");

endmodule

### sv/pms_drive_stage.sv
`timescale 1ns / 1ps

module pms_drive_stage #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  pms_pkg::cfg_t                        cfg,
	input  logic                                 valid_s2,
	input  pms_pkg::step_t                       step_s2,
	output logic                                 res_valid,
	output logic signed [pms_pkg::WORD_W-1:0]    res_rpm,
	output logic signed [pms_pkg::DRIVE_W-1:0]   res_drive
);
	import pms_pkg::*;

	localparam logic signed [ACC_W-1:0] BIAS =
		{{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

	logic                      valid_s3;
	logic signed [WORD_W-1:0]  rpm_s3;
	logic                      zero_s3;
	logic signed [PP_W-1:0]    pp_s3;
	logic signed [PI_W-1:0]    pi_s3;
	logic signed [PD_W-1:0]    pd_s3;

	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   biased;
	logic signed [ACC_W-1:0]   quo;
	logic signed [ACC_W-1:0]   lim;
	logic signed [ACC_W-1:0]   drv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rpm_s3  <= step_s2.rpm;
			zero_s3 <= step_s2.tgt_zero;
			pp_s3   <= $signed({1'b0, cfg.prop_gain}) * step_s2.err;
			pi_s3   <= $signed({1'b0, cfg.integ_gain}) * step_s2.sum;
			pd_s3   <= $signed({1'b0, cfg.deriv_gain}) * step_s2.deriv;
		end
	end

	// Sum, truncate toward zero, clamp; force zero drive when the target is zero
	always_comb begin
		acc    = ACC_W'(pp_s3) + ACC_W'(pi_s3) + ACC_W'(pd_s3);
		biased = acc[ACC_W-1] ? acc + BIAS : acc;
		quo    = biased >>> GAIN_FRAC_BITS;
		lim    = $signed({{(ACC_W-DLIM_W){1'b0}}, cfg.drive_limit});
		if (zero_s3)
			drv = '0;
		else if (quo > lim)
			drv = lim;
		else if (quo < -lim)
			drv = -lim;
		else
			drv = quo;
	end

	assign res_valid = valid_s3;
	assign res_rpm   = rpm_s3;
	assign res_drive = drv[DRIVE_W-1:0];

	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (drv <= lim) && (drv >= -lim))
		else $error("drive outside its limit");

endmodule

### sv/pms_out_buf.sv
`timescale 1ns / 1ps

module pms_out_buf (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic signed [pms_pkg::WORD_W-1:0]    res_rpm,
	input  logic signed [pms_pkg::DRIVE_W-1:0]   res_drive,
	output logic                                 skid_full,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pms_pkg::WORD_W-1:0]    measured_rpm,
	output logic signed [pms_pkg::DRIVE_W-1:0]   drive_level
);
	import pms_pkg::*;

	logic                      out_valid_q;
	logic signed [WORD_W-1:0]  rpm_q;
	logic signed [DRIVE_W-1:0] drv_q;
	logic                      skid_valid_q;
	logic signed [WORD_W-1:0]  skid_rpm_q;
	logic signed [DRIVE_W-1:0] skid_drv_q;
	logic                      out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || load;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				rpm_q <= skid_rpm_q;
				drv_q <= skid_drv_q;
			end else if (load) begin
				rpm_q <= res_rpm;
				drv_q <= res_drive;
			end
		end else if (load) begin
			skid_rpm_q <= res_rpm;
			skid_drv_q <= res_drive;
		end
	end

	assign skid_full    = skid_valid_q;
	assign out_valid    = out_valid_q;
	assign measured_rpm = rpm_q;
	assign drive_level  = drv_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without a stalled output");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !load)
		else $error("result arrived while skid was full");

endmodule
